// File: hw/rtl/gms_pkg.sv
`default_nettype none

package gms_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int GID_W          = 10;
  localparam int SUM_W          = 48;
  localparam int MAX_GROUPS_DEF = 1024;
  localparam int MAX_ROWS_DEF   = 65536;

  typedef enum logic {
    FUNC_ACCUM  = 1'b0,
    FUNC_OUTPUT = 1'b1
  } func_t;

endpackage

`default_nettype wire

// File: hw/rtl/group_mean_subtract.sv
// Channel  Ports                                                   Beat
// in       in_valid/in_ready, in_func, in_sample, in_group_id,     one row
//          in_end_of_column
// out      out_valid/out_ready, out_demeaned, out_empty_group,     one demeaned row
//          out_saturated, out_last_row
//
// Accumulate row: accept, then read-modify-write of the group store.
// Output row: accept, store read, 48 restoring divide steps of the one shared
// subtractor, result, output register load; an empty group skips divide and result.
// After reset and after an output row with end_of_column set, the group store is
// swept to zero, one entry a cycle, over all MAX_GROUPS entries with in_ready low.
// A finished result waits in the output register; a new row is taken meanwhile,
// and only the next result's load stalls on out_ready.
`default_nettype none

module group_mean_subtract #(
  parameter int MAX_GROUPS = gms_pkg::MAX_GROUPS_DEF,
  parameter int MAX_ROWS   = gms_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic signed [gms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic        [gms_pkg::GID_W-1:0]    in_group_id,
  input  logic                                in_end_of_column,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gms_pkg::SAMPLE_W-1:0] out_demeaned,
  output logic                                out_empty_group,
  output logic                                out_saturated,
  output logic                                out_last_row
);
  import gms_pkg::*;

  localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int MW = SUM_W + RW;
  localparam int CW = $clog2(SUM_W + 1);
  localparam int DW = SUM_W + 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DIV,
    S_DONE,
    S_OUT
  } state_t;

  state_t                     state_r;
  logic [AW-1:0]              clr_cnt_r;
  func_t                      func_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]              addr_r;
  logic                       gvalid_r;
  logic                       eoc_r;

  logic [MW-1:0]              mem [MAX_GROUPS];
  logic [MW-1:0]              rd_data_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [MW-1:0]              mem_wdata;

  logic [SUM_W-1:0]           dvd_r;
  logic [RW-1:0]              rem_r;
  logic [RW-1:0]              dvs_r;
  logic [CW-1:0]              cnt_r;
  logic                       neg_r;

  logic signed [SAMPLE_W-1:0] res_demeaned_r;
  logic                       res_empty_r;
  logic                       res_sat_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_demeaned_r;
  logic                       out_empty_r;
  logic                       out_sat_r;
  logic                       out_last_r;

  logic                       in_accept;
  logic [31:0]                gid_ext;
  logic [AW-1:0]              rd_addr;
  logic                       in_gvalid;

  logic signed [SUM_W-1:0]    rd_sum;
  logic [RW-1:0]              rd_rows;
  logic signed [SUM_W:0]      acc_sum;
  logic [SUM_W-1:0]           acc_clip;
  logic                       rows_full;
  logic [RW-1:0]              rows_inc;
  logic [SUM_W-1:0]           sum_mag;
  logic                       grp_empty;

  logic [RW:0]                rem_sh;
  logic [RW:0]                rem_sub;
  logic                       rem_ge;
  logic [RW-1:0]              rem_nxt;

  logic signed [SUM_W:0]      mean_mag;
  logic signed [SUM_W:0]      mean;
  logic signed [DW-1:0]       diff;
  logic [DW-SAMPLE_W:0]       diff_hi;
  logic                       diff_fits;
  logic [SAMPLE_W-1:0]        diff_sat;
  logic                       out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  assign gid_ext   = 32'(in_group_id);
  assign rd_addr   = gid_ext[AW-1:0];
  assign in_gvalid = gid_ext < 32'(MAX_GROUPS);

  // group store entry: {sum, row count}
  assign rd_sum  = rd_data_r[MW-1:RW];
  assign rd_rows = rd_data_r[RW-1:0];

  assign acc_sum   = (SUM_W+1)'(rd_sum) + (SUM_W+1)'(sample_r);
  assign acc_clip  = (acc_sum[SUM_W] != acc_sum[SUM_W-1]) ?
                     {acc_sum[SUM_W], {(SUM_W-1){~acc_sum[SUM_W]}}} :
                     acc_sum[SUM_W-1:0];
  assign rows_full = rd_rows >= RW'(MAX_ROWS);
  assign rows_inc  = rd_rows + RW'(1);
  assign sum_mag   = rd_sum[SUM_W-1] ? (~rd_data_r[MW-1:RW] + 1'b1) : rd_data_r[MW-1:RW];
  assign grp_empty = !gvalid_r || (rd_rows == '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = {acc_clip, rows_inc};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == S_LOOKUP && func_r == FUNC_ACCUM && gvalid_r && !rows_full) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // restoring divide step on the magnitude of the sum
  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign rem_nxt = rem_ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];

  assign mean_mag  = {1'b0, dvd_r};
  assign mean      = neg_r ? -mean_mag : mean_mag;
  assign diff      = DW'(sample_r) - DW'(mean);
  assign diff_hi   = diff[DW-1:SAMPLE_W-1];
  assign diff_fits = (&diff_hi) || (~|diff_hi);
  assign diff_sat  = {diff[DW-1], {(SAMPLE_W-1){~diff[DW-1]}}};

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(MAX_GROUPS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            func_r   <= func_t'(in_func);
            sample_r <= in_sample;
            addr_r   <= rd_addr;
            gvalid_r <= in_gvalid;
            eoc_r    <= in_end_of_column;
            state_r  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (func_r == FUNC_ACCUM) begin
            state_r <= S_IDLE;
          end else if (grp_empty) begin
            res_demeaned_r <= sample_r;
            res_empty_r    <= 1'b1;
            res_sat_r      <= 1'b0;
            state_r        <= S_OUT;
          end else begin
            dvd_r   <= sum_mag;
            rem_r   <= '0;
            dvs_r   <= rd_rows;
            neg_r   <= rd_sum[SUM_W-1];
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          dvd_r <= {dvd_r[SUM_W-2:0], rem_ge};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(SUM_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          res_demeaned_r <= diff_fits ? diff[SAMPLE_W-1:0] : diff_sat;
          res_empty_r    <= 1'b0;
          res_sat_r      <= !diff_fits;
          state_r        <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r    <= 1'b1;
            out_demeaned_r <= res_demeaned_r;
            out_empty_r    <= res_empty_r;
            out_sat_r      <= res_sat_r;
            out_last_r     <= eoc_r;
            clr_cnt_r      <= '0;
            state_r        <= eoc_r ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_demeaned    = out_demeaned_r;
  assign out_empty_group = out_empty_r;
  assign out_saturated   = out_sat_r;
  assign out_last_row    = out_last_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < CW'(SUM_W))
    else $error("divide step count overran");

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < dvs_r)
    else $error("partial remainder not below row count");

  a_empty_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_empty_group && out_saturated))
    else $error("empty group beat flagged saturated");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> mem_we && (mem_wdata == '0) && !in_ready)
    else $error("clear sweep not writing zero");

endmodule

`default_nettype wire

// File: tb/demean_check.sv
`timescale 1ns / 100ps

module demean_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_func,
  input  logic signed [gms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic        [gms_pkg::GID_W-1:0]    in_group_id,
  input  logic                                in_end_of_column,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [gms_pkg::SAMPLE_W-1:0] out_demeaned,
  input  logic                                out_empty_group,
  input  logic                                out_saturated,
  input  logic                                out_last_row,
  output int                                  mismatches,
  output int                                  rows_pending
);
  import gms_pkg::*;

  localparam int     NUM_GROUPS = MAX_GROUPS_DEF;
  localparam int     ROW_LIMIT  = MAX_ROWS_DEF;
  localparam longint SUM_HI     = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO     = -SUM_HI - 1;
  localparam longint DIFF_HI    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint DIFF_LO    = -DIFF_HI - 1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] demeaned;
    logic                       empty_group;
    logic                       saturated;
    logic                       last_row;
  } demeaned_row_t;

  longint        group_total [NUM_GROUPS];
  int unsigned   group_count [NUM_GROUPS];
  demeaned_row_t expected_rows [$];
  int            fails = 0;

  task automatic clear_groups();
    foreach (group_total[g]) begin
      group_total[g] = 0;
      group_count[g] = 0;
    end
  endtask

  task automatic accumulate_row(input logic signed [SAMPLE_W-1:0] sample,
                                input logic [GID_W-1:0] gid);
    longint total;
    // rows past the per-group limit are dropped
    if (gid < NUM_GROUPS && group_count[gid] < ROW_LIMIT) begin
      total = group_total[gid] + longint'(sample);
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      group_total[gid] = total;
      group_count[gid]++;
    end
  endtask

  function automatic demeaned_row_t demean_row(input logic signed [SAMPLE_W-1:0] sample,
                                               input logic [GID_W-1:0] gid,
                                               input logic eoc);
    demeaned_row_t r;
    longint        mean;
    longint        diff;
    r = '{default: '0};
    r.last_row = eoc;
    if (gid >= NUM_GROUPS || group_count[gid] == 0) begin
      r.demeaned    = sample;
      r.empty_group = 1'b1;
    end else begin
      // signed divide truncates toward zero
      mean = group_total[gid] / longint'(group_count[gid]);
      diff = longint'(sample) - mean;
      if (diff > DIFF_HI) begin
        diff        = DIFF_HI;
        r.saturated = 1'b1;
      end else if (diff < DIFF_LO) begin
        diff        = DIFF_LO;
        r.saturated = 1'b1;
      end
      r.demeaned = diff[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    demeaned_row_t want;
    if (!rst_n) begin
      clear_groups();
      expected_rows.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          fails++;
          $error("result beat with no row waiting: demeaned %0d", out_demeaned);
        end else begin
          want = expected_rows.pop_front();
          check_field("demeaned", want.demeaned, out_demeaned);
          check_field("empty_group", want.empty_group, out_empty_group);
          check_field("saturated", want.saturated, out_saturated);
          check_field("last_row", want.last_row, out_last_row);
        end
      end
      if (in_valid && in_ready) begin
        if (func_t'(in_func) == FUNC_ACCUM) begin
          accumulate_row(in_sample, in_group_id);
        end else begin
          expected_rows.insert(expected_rows.size(),
                               demean_row(in_sample, in_group_id, in_end_of_column));
          if (in_end_of_column) clear_groups();
        end
      end
    end
    mismatches   <= fails;
    rows_pending <= expected_rows.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gms_pkg::*;

  localparam int RANDOM_ROWS = 1550;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_ready;
  logic                       in_func          = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample        = '0;
  logic        [GID_W-1:0]    in_group_id      = '0;
  logic                       in_end_of_column = 1'b0;
  logic                       out_valid;
  logic                       out_ready        = 1'b0;
  logic signed [SAMPLE_W-1:0] out_demeaned;
  logic                       out_empty_group;
  logic                       out_saturated;
  logic                       out_last_row;
  logic                       steady           = 1'b0;
  int                         fails;
  int                         rows_pending;
  int                         rows_sent        = 0;

  always #4 clk = ~clk;

  group_mean_subtract dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_sample        (in_sample),
    .in_group_id      (in_group_id),
    .in_end_of_column (in_end_of_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_demeaned     (out_demeaned),
    .out_empty_group  (out_empty_group),
    .out_saturated    (out_saturated),
    .out_last_row     (out_last_row)
  );

  demean_check row_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_sample        (in_sample),
    .in_group_id      (in_group_id),
    .in_end_of_column (in_end_of_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_demeaned     (out_demeaned),
    .out_empty_group  (out_empty_group),
    .out_saturated    (out_saturated),
    .out_last_row     (out_last_row),
    .mismatches       (fails),
    .rows_pending     (rows_pending)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  // valid stays up between back-to-back beats; it only drops inside a gap
  task automatic send_row(input func_t f, input logic [SAMPLE_W-1:0] s,
                          input logic [GID_W-1:0] g, input logic eoc);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_sample        <= s;
    in_group_id      <= g;
    in_end_of_column <= eoc;
    do @(posedge clk); while (!in_ready);
    rows_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      4:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_column();
    logic [GID_W-1:0] groups [8];
    int               ngroups;
    int               nrows;
    func_t            f;
    logic [GID_W-1:0] g;
    ngroups = $urandom_range(1, 8);
    foreach (groups[i]) groups[i] = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 9) == 0) begin
      // broken column: passes interleaved, end marker rare or missing
      nrows = $urandom_range(3, 15);
      repeat (nrows) begin
        f = func_t'($urandom_range(0, 1));
        g = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                        : groups[$urandom_range(0, ngroups - 1)];
        send_row(f, pick_sample(), g,
                 (f == FUNC_OUTPUT) ? ($urandom_range(0, 7) == 0)
                                    : 1'($urandom_range(0, 1)));
      end
    end else begin
      nrows = $urandom_range(1, 16);
      repeat (nrows)
        send_row(FUNC_ACCUM, pick_sample(), groups[$urandom_range(0, ngroups - 1)],
                 1'($urandom_range(0, 1)));
      nrows = $urandom_range(1, 10);
      for (int i = 0; i < nrows; i++) begin
        g = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                        : groups[$urandom_range(0, ngroups - 1)];
        send_row(FUNC_OUTPUT, pick_sample(), g, i == nrows - 1);
      end
    end
  endtask

  initial begin
    int start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, truncation toward zero, empty group, eoc ignored on accumulate
    send_row(FUNC_ACCUM, 32'h7FFF_FFFF, 10'd0, 1'b0);
    send_row(FUNC_ACCUM, 32'h7FFF_FFFF, 10'd0, 1'b1);
    send_row(FUNC_ACCUM, 32'h8000_0000, 10'd1023, 1'b0);
    send_row(FUNC_ACCUM, 32'h8000_0000, 10'd1023, 1'b0);
    send_row(FUNC_ACCUM, 3, 10'd5, 1'b0);
    send_row(FUNC_ACCUM, -4, 10'd5, 1'b0);
    send_row(FUNC_ACCUM, -7, 10'd7, 1'b0);
    send_row(FUNC_ACCUM, 0, 10'd7, 1'b0);
    send_row(FUNC_ACCUM, 0, 10'd7, 1'b0);
    send_row(FUNC_OUTPUT, 32'h8000_0000, 10'd0, 1'b0);
    send_row(FUNC_OUTPUT, 32'h7FFF_FFFF, 10'd1023, 1'b0);
    send_row(FUNC_OUTPUT, 5, 10'd5, 1'b0);
    send_row(FUNC_OUTPUT, -1, 10'd7, 1'b0);
    send_row(FUNC_OUTPUT, 32'h8000_0000, 10'd3, 1'b0);
    send_row(FUNC_OUTPUT, 32'h7FFF_FFFF, 10'd0, 1'b0);
    send_row(FUNC_OUTPUT, 0, 10'd1023, 1'b1);
    // store must be clear after the column end
    send_row(FUNC_ACCUM, 100, 10'd2, 1'b1);
    send_row(FUNC_OUTPUT, 32'h8000_0000, 10'd0, 1'b0);
    send_row(FUNC_OUTPUT, 32'h7FFF_FFFF, 10'd2, 1'b0);
    send_row(FUNC_OUTPUT, 32'hFFFF_FFFF, 10'd1023, 1'b1);

    start = rows_sent;
    while (rows_sent - start < RANDOM_ROWS) begin
      steady <= (rows_sent - start >= 600) && (rows_sent - start < 900);
      run_column();
    end
    steady   <= 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (rows_pending != 0);
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("group_mean_subtract verification clean");
    end else begin
      $display("group_mean_subtract verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("group_mean_subtract verification failed");
    $finish;
  end

endmodule
